// ----- design/uar_pkg.sv -----
`timescale 1ns / 1ps

package uar_pkg;

  // fixed field widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 6;

  // parameter defaults
  localparam int unsigned DEF_VALUE_BITS = 64;
  localparam int unsigned DEF_MAX_DIGITS = 64;

  // quotient bits resolved per divider cycle
  localparam int unsigned STEP_BITS = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 6'd9;
  localparam logic [CHAR_W-1:0] LETTER_BASE  = 7'd10;

  typedef struct packed {
    logic start;
    logic load;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               quo_zero;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] res;
    if (d > DIGIT_NINE) begin
      res = CHAR_W'(d) - LETTER_BASE + (upper ? CHAR_UPPER_A : CHAR_LOWER_A);
    end else begin
      res = CHAR_W'(d) + CHAR_ZERO;
    end
    return res;
  endfunction

endpackage

// ----- design/uar_if.sv -----
`timescale 1ns / 1ps

interface uar_in_if;
  import uar_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;
  logic               upper_case;
  logic               negative;

  modport source (output valid, value, radix, upper_case, negative, input ready);
  modport sink   (input valid, value, radix, upper_case, negative, output ready);
endinterface

interface uar_out_if;
  import uar_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              minus_before;
  logic              last;

  modport source (output valid, ascii_char, minus_before, last, input ready);
  modport sink   (input valid, ascii_char, minus_before, last, output ready);
endinterface

// ----- design/uar_div.sv -----
`timescale 1ns / 1ps

module uar_div #(
  parameter int unsigned VALUE_BITS = uar_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  uar_pkg::div_ctrl_t          ctrl_i,
  input  logic [VALUE_BITS-1:0]       value_i,
  input  logic [uar_pkg::RADIX_W-1:0] divisor_i,
  output uar_pkg::div_stat_t          stat_o
);
  import uar_pkg::*;

  localparam int unsigned STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned WP    = STEPS * STEP_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [WP-1:0]      work_q, work_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [DIGIT_W:0]   r;
  logic [STEP_BITS-1:0] qb;

  // restoring division, STEP_BITS quotient bits per cycle, msb first
  always_comb begin
    r  = {1'b0, rem_q};
    qb = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[DIGIT_W-1:0], work_q[WP-1-i]};
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
        qb[STEP_BITS-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      work_d = ctrl_i.load ? WP'(value_i) : work_q;
      rem_d  = '0;
      cnt_d  = CNT_W'(STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits enter at the bottom as dividend bits leave the top
      work_d = (work_q << STEP_BITS) | WP'(qb);
      rem_d  = r[DIGIT_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.quo_zero = (work_q == '0);
  assign stat_o.rem      = rem_q;

endmodule

// ----- design/uar_digit_buf.sv -----
`timescale 1ns / 1ps

module uar_digit_buf #(
  parameter int unsigned MAX_DIGITS = uar_pkg::DEF_MAX_DIGITS,
  parameter int unsigned AW         = $clog2(MAX_DIGITS)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [uar_pkg::DIGIT_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [uar_pkg::DIGIT_W-1:0] rdata_o
);
  import uar_pkg::*;

  logic [DIGIT_W-1:0] mem_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/unsigned_to_ascii_radix_unit.sv -----
`timescale 1ns / 1ps

// Converts an unsigned value to ASCII digits in base 2..36 (out-of-range bases
// saturate), most significant digit first, one digit per output beat, with
// last on the final digit and minus_before on the first digit when negative
// is set. One input is handled at a time and in_i.ready stays low until the
// last digit beat is taken. A shared divider produces each digit with one
// division, resolving 8 quotient bits per cycle; digits go into a small
// buffer and are read back in reverse, each read (S_RD) followed by a digit
// beat (S_OUT) that holds until the output takes it. A value needing more
// than MAX_DIGITS digits yields only its MAX_DIGITS low-order digits.
module unsigned_to_ascii_radix_unit #(
  parameter int unsigned VALUE_BITS = uar_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_DIGITS = uar_pkg::DEF_MAX_DIGITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uar_in_if.sink    in_i,
  uar_out_if.source out_o
);
  import uar_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               case_q, case_d;
  logic               sign_q, sign_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               first_q, first_d;

  div_ctrl_t          div_ctl;
  div_stat_t          div_st;
  logic               buf_we, buf_re;
  logic [DIGIT_W-1:0] buf_rdata;
  logic [RADIX_W-1:0] radix_sat;
  logic               in_acc, out_acc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  always_comb begin
    priority if (in_i.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_i.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_i.radix;
    end
  end

  always_comb begin
    state_d       = state_q;
    radix_d       = radix_q;
    case_d        = case_q;
    sign_d        = sign_q;
    cnt_d         = cnt_q;
    rd_idx_d      = rd_idx_q;
    first_d       = first_q;
    div_ctl.start = 1'b0;
    div_ctl.load  = 1'b0;
    buf_we        = 1'b0;
    buf_re        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          radix_d       = radix_sat;
          case_d        = in_i.upper_case;
          sign_d        = in_i.negative;
          cnt_d         = '0;
          first_d       = 1'b1;
          div_ctl.start = 1'b1;
          div_ctl.load  = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          // a zero value still yields its single '0' on the first pass
          if (div_st.quo_zero || cnt_q == CW'(MAX_DIGITS - 1)) begin
            rd_idx_d = cnt_q[AW-1:0];
            state_d  = S_RD;
          end else begin
            div_ctl.start = 1'b1;
          end
        end
      end
      S_RD: begin
        buf_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          first_d = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      radix_q  <= RADIX_RESET;
      case_q   <= 1'b0;
      sign_q   <= 1'b0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      radix_q  <= radix_d;
      case_q   <= case_d;
      sign_q   <= sign_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      first_q  <= first_d;
    end
  end

  uar_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctl),
    .value_i  (in_i.value[VALUE_BITS-1:0]),
    .divisor_i(radix_q),
    .stat_o   (div_st)
  );

  uar_digit_buf #(
    .MAX_DIGITS(MAX_DIGITS),
    .AW        (AW)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(div_st.rem),
    .re_i   (buf_re),
    .raddr_i(rd_idx_q),
    .rdata_o(buf_rdata)
  );

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.ascii_char   = digit_char(buf_rdata, case_q);
  assign out_o.minus_before = first_q && sign_q;
  assign out_o.last         = (rd_idx_q == '0);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a digit beat is pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("block not ready after last digit");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");
`endif

endmodule

// ----- tb/tb_unsigned_to_ascii_radix_unit.sv -----
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_radix_unit;
  import uar_pkg::*;

  localparam int unsigned VALUE_BITS  = DEF_VALUE_BITS;
  localparam int unsigned MAX_DIGITS  = DEF_MAX_DIGITS;
  localparam int unsigned RAND_ITEMS  = 450;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               upper;
    logic               neg;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              minus;
    logic              last;
  } digit_beat_t;

  typedef struct {
    conv_req_t rq;
    string     want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  uar_in_if  in_if ();
  uar_out_if out_if ();

  unsigned_to_ascii_radix_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  digit_beat_t pending_digits[$];
  dir_row_t    dir_rows[$];
  int unsigned errors = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  bit          hold_off_req = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int unsigned eff_base(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return 32'(RADIX_MIN);
    if (r > RADIX_MAX) return 32'(RADIX_MAX);
    return 32'(r);
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                input logic upper);
    if (d > DIGIT_NINE) return CHAR_W'(d) - LETTER_BASE + (upper ? CHAR_UPPER_A : CHAR_LOWER_A);
    return CHAR_W'(d) + CHAR_ZERO;
  endfunction

  // divide down, keep the low-order digits, replay most significant first
  function automatic void predict_digits(input conv_req_t rq);
    logic [VALUE_W-1:0] v;
    logic [DIGIT_W-1:0] dig [64];
    int unsigned base;
    int unsigned n;
    digit_beat_t b;
    base = eff_base(rq.radix);
    v = rq.value & VALUE_MASK;
    n = 0;
    if (v == 0) begin
      dig[0] = '0;
      n = 1;
    end else begin
      while (v != 0 && n < MAX_DIGITS) begin
        dig[n] = DIGIT_W'(v % 64'(base));
        v = v / 64'(base);
        n++;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      b.ch    = char_of(dig[n-1-k], rq.upper);
      b.minus = rq.neg && (k == 0);
      b.last  = (k == n - 1);
      pending_digits.push_back(b);
    end
  endfunction

  function automatic void expect_text(input conv_req_t rq, input string want);
    digit_beat_t b;
    byte c;
    for (int i = 0; i < want.len(); i++) begin
      c       = want[i];
      b.ch    = c[CHAR_W-1:0];
      b.minus = rq.neg && (i == 0);
      b.last  = (i == want.len() - 1);
      pending_digits.push_back(b);
    end
  endfunction

  function automatic void add_row(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                                  input logic up, input logic ng, input string want);
    dir_row_t row;
    row.rq   = '{value: v, radix: r, upper: up, neg: ng};
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value(input int unsigned base);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int unsigned k;
    case ($urandom_range(0, 9))
      0: v = 64'($urandom_range(0, base * base));
      1, 2: v = {$urandom, $urandom};
      3: begin
        // near a power of the base, where the digit count steps
        p = 64'd1;
        k = $urandom_range(1, 64);
        repeat (k) if (p <= '1 / 64'(base)) p = p * 64'(base);
        v = p - 64'($urandom_range(0, 1));
      end
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic offer(input conv_req_t rq, input string want, input bit drain);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.value      <= rq.value;
    in_if.radix      <= rq.radix;
    in_if.upper_case <= rq.upper;
    in_if.negative   <= rq.neg;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (want.len() != 0) expect_text(rq, want);
    else predict_digits(rq);
    gap = draw_wait(quiet_in);
    if (drain || gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) while (pending_digits.size() != 0) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    conv_req_t rq;
    in_if.valid      <= 1'b0;
    in_if.value      <= '0;
    in_if.radix      <= RADIX_RESET;
    in_if.upper_case <= 1'b0;
    in_if.negative   <= 1'b0;

    add_row(64'd0, 6'd10, 1'b0, 1'b0, "0");
    add_row(64'd0, 6'd2, 1'b1, 1'b1, "0");
    add_row('1, 6'd16, 1'b1, 1'b0, "FFFFFFFFFFFFFFFF");
    add_row('1, 6'd16, 1'b0, 1'b1, "ffffffffffffffff");
    add_row('1, 6'd10, 1'b0, 1'b0, "18446744073709551615");
    add_row('1, 6'd2, 1'b0, 1'b0, "");
    add_row('1, 6'd36, 1'b1, 1'b1, "");
    add_row(64'h8000_0000_0000_0000, 6'd2, 1'b0, 1'b1, "");
    add_row(64'd1, 6'd2, 1'b0, 1'b1, "1");
    add_row(64'd35, 6'd36, 1'b0, 1'b0, "z");
    add_row(64'd35, 6'd36, 1'b1, 1'b0, "Z");
    add_row(64'd10, 6'd11, 1'b1, 1'b0, "A");
    // bases below two and above thirty-six saturate
    add_row(64'd5, 6'd0, 1'b0, 1'b0, "101");
    add_row(64'd6, 6'd1, 1'b0, 1'b0, "110");
    add_row(64'd36, 6'd37, 1'b1, 1'b0, "10");
    add_row(64'd35, 6'd63, 1'b0, 1'b1, "z");
    add_row(64'd1, 6'd63, 1'b1, 1'b0, "1");
    add_row(64'd9, 6'd10, 1'b0, 1'b0, "9");
    add_row(64'd999, 6'd10, 1'b0, 1'b1, "999");
    add_row(64'h0123_4567_89ab_cdef, 6'd16, 1'b0, 1'b0, "123456789abcdef");
    add_row(64'hfedc_ba98_7654_3210, 6'd16, 1'b1, 1'b0, "FEDCBA9876543210");
    add_row(64'd12345, 6'd7, 1'b0, 1'b0, "");
    add_row(64'h5555_5555_5555_5555, 6'd8, 1'b1, 1'b1, "");
    add_row(64'haaaa_aaaa_aaaa_aaaa, 6'd3, 1'b0, 1'b0, "");

    wait (rst_n);
    @(posedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].rq, dir_rows[i].want, 1'b0);

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      if (i == 120) hold_off_req = 1'b1;
      if ($urandom_range(0, 7) == 0) rq.radix = RADIX_W'($urandom_range(0, 63));
      else rq.radix = RADIX_W'($urandom_range(2, 36));
      rq.upper = 1'($urandom_range(0, 1));
      rq.neg   = 1'($urandom_range(0, 1));
      rq.value = draw_value(eff_base(rq.radix));
      offer(rq, "", (i == 300) || (i == RAND_ITEMS - 1));
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver
  initial begin
    int unsigned stall;
    int unsigned beats;
    digit_beat_t b;
    beats = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (beats % 64 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      if (hold_off_req) begin
        // long hold-off so a digit beat waits and the block stalls its input
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(quiet_out);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      beats++;
      if (pending_digits.size() == 0) begin
        report($sformatf("beat with no digit pending, char %0d", out_if.ascii_char));
      end else begin
        b = pending_digits.pop_front();
        if (out_if.ascii_char !== b.ch)
          report($sformatf("ascii_char got %0d want %0d", out_if.ascii_char, b.ch));
        if (out_if.minus_before !== b.minus)
          report($sformatf("minus_before got %b want %b", out_if.minus_before, b.minus));
        if (out_if.last !== b.last)
          report($sformatf("last got %b want %b", out_if.last, b.last));
      end
    end
  end

endmodule

// ----- filelist.f -----
design/uar_pkg.sv
design/uar_if.sv
design/uar_div.sv
design/uar_digit_buf.sv
design/unsigned_to_ascii_radix_unit.sv
tb/tb_unsigned_to_ascii_radix_unit.sv
